>>> rtl/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  localparam logic [31:0] HEAP_BASE = 32'h0080_0000;
  localparam int unsigned MB_SHIFT  = 20;
  localparam logic [11:0] MB_LIMIT  = 12'd3064;

  localparam int unsigned APB_AW      = 3;
  localparam logic        REG_HEAP_MB = 1'b0;

  typedef enum logic [1:0] {
    MODE_ALLOC,
    MODE_RELEASE,
    MODE_RESIZE,
    MODE_STATS
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOMEM,
    STAT_UNKNOWN
  } status_e;

  typedef enum logic [1:0] {
    WALK_ALLOC,
    WALK_FIND,
    WALK_STATS
  } walk_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_WALK,
    ST_FOUND,
    ST_SCAN,
    ST_SPLIT_NEW,
    ST_TAKE,
    ST_REFIND,
    ST_REL,
    ST_REL_NEXT,
    ST_REL_PREV,
    ST_DONE
  } state_e;

endpackage

>>> rtl/first_fit_heap_allocator.sv
// channel | direction | handshake              | payload
// config  | in/out    | psel, penable, pwrite  | paddr, pwdata, prdata
// request | in        | in_valid_i/in_ready_o  | mode_i, request_size_i, block_address_i
// result  | out       | out_valid_o/out_ready_i| status_o ... largest_free_bytes_o
//
// A request walks the block table one entry per cycle through a single read port.
// Allocate: walk and take, plus a scan of up to MAX_BLOCKS slots and one write on a split.
// Release: walk, merge with a free next block (if any), then with a free previous block.
// A moving resize walks three times. Statistics: one walk over every block.
// After reset and after every heap size write, the ST_INIT state rebuilds the table.
// A finished result waits in the output register while the next request is taken.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [31:0]       request_size_i,
  input  logic [31:0]       block_address_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [31:0]       result_address_o,
  output logic [31:0]       copy_bytes_o,
  output logic [6:0]        block_count_o,
  output logic [6:0]        alloc_count_o,
  output logic [6:0]        vacant_count_o,
  output logic [31:0]       used_bytes_o,
  output logic [31:0]       free_bytes_o,
  output logic [31:0]       largest_free_bytes_o
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned PTR_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_BLOCKS);
  localparam logic [31:0] HB32 = 32'(HEADER_BYTES);
  localparam logic [33:0] KEY_OFS = 34'(HEAP_BASE) + 34'(HEADER_BYTES);
  localparam logic [33:0] SPLIT_OFS = 34'(HEADER_BYTES + 8);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_BLOCKS - 1);

  typedef struct packed {
    logic [31:0]      off;
    logic [31:0]      size;
    logic             free;
    logic [PTR_W-1:0] nxt;
  } entry_t;

  state_e state_q, state_d;
  logic [11:0] heap_mb_q, heap_mb_d;
  logic [MAX_BLOCKS-1:0] in_use_q, in_use_d;
  mode_e mode_q, mode_d;
  logic [31:0] size_q, size_d, addr_q, addr_d;
  logic [33:0] need_q, need_d, split_q, split_d, key_q, key_d;
  walk_e walk_q, walk_d;
  logic refind_q, refind_d, move_q, move_d, do_split_q, do_split_d;
  logic [PTR_W-1:0] cur_q, cur_d, prev_idx_q, prev_idx_d, rel_idx_q, rel_idx_d;
  entry_t prev_ent_q, prev_ent_d, rel_ent_q, rel_ent_d;
  logic [IDX_W-1:0] spare_q, spare_d, scan_q, scan_d;
  status_e wstat_q, wstat_d;
  logic [31:0] waddr_q, waddr_d, wcopy_q, wcopy_d;
  logic [6:0] tot_q, tot_d, usedb_q, usedb_d, freeb_q, freeb_d;
  logic [31:0] usedsz_q, usedsz_d, freesz_q, freesz_d, largest_q, largest_d;
  logic out_valid_q, out_valid_d;
  logic [1:0] ostat_q, ostat_d;
  logic [31:0] oaddr_q, oaddr_d, ocopy_q, ocopy_d;
  logic [6:0] otot_q, otot_d, oused_q, oused_d, ofree_q, ofree_d;
  logic [31:0] ousedsz_q, ousedsz_d, ofreesz_q, ofreesz_d, olarge_q, olarge_d;

  entry_t mem [MAX_BLOCKS];
  entry_t rdata_q, wd, e;
  logic rd_en, we;
  logic [IDX_W-1:0] raddr, wa;

  logic cfg_wr, heap_zero, last, alloc_hit, big, find_hit, fits;
  logic [31:0] heap_payload;
  logic [11:0] mb_sat;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_HEAP_MB);
  assign prdata    = (paddr[2] == REG_HEAP_MB) ? {20'd0, heap_mb_q} : 32'd0;
  assign mb_sat    = (pwdata[11:0] > MB_LIMIT) ? MB_LIMIT : pwdata[11:0];
  assign heap_zero = (heap_mb_q == 12'd0);
  assign heap_payload = heap_zero ? 32'd0 : ({heap_mb_q, 20'd0} - HB32);

  assign e         = rdata_q;
  assign last      = (e.nxt == NIL);
  assign alloc_hit = e.free && ({2'b00, e.size} >= need_q);
  assign big       = ({2'b00, e.size} >= split_q);
  assign find_hit  = !e.free && (key_q[33:32] == 2'b00) && (e.off == key_q[31:0]);
  assign fits      = (e.size >= size_q);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (heap_zero) begin
          state_d = ST_DONE;
        end else begin
          case (mode_q)
            MODE_ALLOC:   state_d = (size_q == 32'd0) ? ST_DONE : ST_WALK;
            MODE_RELEASE: state_d = (addr_q == 32'd0) ? ST_DONE : ST_WALK;
            MODE_RESIZE: begin
              state_d = ((addr_q == 32'd0) && (size_q == 32'd0)) ? ST_DONE : ST_WALK;
            end
            default:      state_d = ST_WALK;
          endcase
        end
      end
      ST_WALK: begin
        case (walk_q)
          WALK_ALLOC: begin
            if (alloc_hit) state_d = big ? ST_SCAN : ST_TAKE;
            else if (last) state_d = ST_DONE;
          end
          WALK_FIND: begin
            if (find_hit)  state_d = ST_FOUND;
            else if (last) state_d = ST_DONE;
          end
          default: begin
            if (last) state_d = ST_DONE;
          end
        endcase
      end
      ST_FOUND: begin
        if ((mode_q == MODE_RELEASE) || refind_q || (size_q == 32'd0)) state_d = ST_REL;
        else if (fits) state_d = ST_DONE;
        else           state_d = ST_WALK;
      end
      ST_SCAN: begin
        if (!in_use_q[scan_q])        state_d = ST_SPLIT_NEW;
        else if (scan_q == LAST_SLOT) state_d = ST_TAKE;
      end
      ST_SPLIT_NEW: state_d = ST_TAKE;
      ST_TAKE:      state_d = move_q ? ST_REFIND : ST_DONE;
      ST_REFIND:    state_d = ST_WALK;
      ST_REL:       state_d = last ? ST_REL_PREV : ST_REL_NEXT;
      ST_REL_NEXT:  state_d = ST_REL_PREV;
      ST_REL_PREV:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_wr) state_d = ST_INIT;
  end

  always_comb begin
    heap_mb_d = heap_mb_q;  in_use_d = in_use_q;
    mode_d = mode_q;  size_d = size_q;  addr_d = addr_q;
    need_d = need_q;  split_d = split_q;  key_d = key_q;
    walk_d = walk_q;  refind_d = refind_q;  move_d = move_q;  do_split_d = do_split_q;
    cur_d = cur_q;  prev_idx_d = prev_idx_q;  rel_idx_d = rel_idx_q;
    prev_ent_d = prev_ent_q;  rel_ent_d = rel_ent_q;
    spare_d = spare_q;  scan_d = scan_q;
    wstat_d = wstat_q;  waddr_d = waddr_q;  wcopy_d = wcopy_q;
    tot_d = tot_q;  usedb_d = usedb_q;  freeb_d = freeb_q;
    usedsz_d = usedsz_q;  freesz_d = freesz_q;  largest_d = largest_q;
    out_valid_d = out_valid_q;
    ostat_d = ostat_q;  oaddr_d = oaddr_q;  ocopy_d = ocopy_q;
    otot_d = otot_q;  oused_d = oused_q;  ofree_d = ofree_q;
    ousedsz_d = ousedsz_q;  ofreesz_d = ofreesz_q;  olarge_d = olarge_q;
    rd_en = 1'b0;  raddr = '0;  we = 1'b0;  wa = '0;  wd = rdata_q;

    if (out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{off: 32'd0, size: heap_payload, free: 1'b1, nxt: NIL};
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_e'(mode_i);
          size_d = request_size_i;
          addr_d = block_address_i;
          need_d = ({2'b00, request_size_i} + 34'd7) & ~34'd7;
          key_d  = {2'b00, block_address_i} - KEY_OFS;
          refind_d = 1'b0;  move_d = 1'b0;
          wstat_d = STAT_OK;  waddr_d = '0;  wcopy_d = '0;
          tot_d = '0;  usedb_d = '0;  freeb_d = '0;
          usedsz_d = '0;  freesz_d = '0;  largest_d = '0;
        end
      end
      ST_DISPATCH: begin
        split_d = need_q + SPLIT_OFS;
        rd_en = 1'b1;
        cur_d = '0;
        prev_idx_d = NIL;
        if (heap_zero) begin
          wstat_d = STAT_NOMEM;
        end else begin
          case (mode_q)
            MODE_ALLOC: begin
              walk_d = WALK_ALLOC;
              if (size_q == 32'd0) wstat_d = STAT_NOMEM;
            end
            MODE_RELEASE: walk_d = WALK_FIND;
            MODE_RESIZE: begin
              walk_d = (addr_q == 32'd0) ? WALK_ALLOC : WALK_FIND;
              if ((addr_q == 32'd0) && (size_q == 32'd0)) wstat_d = STAT_NOMEM;
            end
            default: walk_d = WALK_STATS;
          endcase
        end
      end
      ST_WALK: begin
        case (walk_q)
          WALK_ALLOC: begin
            if (alloc_hit) begin
              do_split_d = big;
              scan_d = '0;
              waddr_d = HEAP_BASE + e.off + HB32;
            end else if (last) begin
              wstat_d = STAT_NOMEM;
              wcopy_d = '0;
            end
          end
          WALK_FIND: begin
            if (!find_hit && last && !refind_q) wstat_d = STAT_UNKNOWN;
          end
          default: begin
            tot_d = tot_q + 7'd1;
            if (e.free) begin
              freeb_d  = freeb_q + 7'd1;
              freesz_d = freesz_q + e.size;
              if (e.size > largest_q) largest_d = e.size;
            end else begin
              usedb_d  = usedb_q + 7'd1;
              usedsz_d = usedsz_q + e.size;
            end
          end
        endcase
        if (!last && !((walk_q == WALK_ALLOC) && alloc_hit)
            && !((walk_q == WALK_FIND) && find_hit)) begin
          rd_en = 1'b1;
          raddr = e.nxt[IDX_W-1:0];
          cur_d = e.nxt;
          prev_idx_d = cur_q;
          prev_ent_d = e;
        end
      end
      ST_FOUND: begin
        if (!((mode_q == MODE_RELEASE) || refind_q || (size_q == 32'd0))) begin
          if (fits) begin
            waddr_d = addr_q;
          end else begin
            wcopy_d = e.size;
            move_d = 1'b1;
            walk_d = WALK_ALLOC;
            rd_en = 1'b1;
            cur_d = '0;
            prev_idx_d = NIL;
          end
        end
      end
      ST_SCAN: begin
        if (!in_use_q[scan_q]) begin
          spare_d = scan_q;
        end else begin
          scan_d = scan_q + 1'b1;
          if (scan_q == LAST_SLOT) do_split_d = 1'b0;
        end
      end
      ST_SPLIT_NEW: begin
        we = 1'b1;
        wa = spare_q;
        wd = '{off: e.off + HB32 + need_q[31:0], size: e.size - need_q[31:0] - HB32,
               free: 1'b1, nxt: e.nxt};
        in_use_d[spare_q] = 1'b1;
      end
      ST_TAKE: begin
        we = 1'b1;
        wa = cur_q[IDX_W-1:0];
        wd = '{off: e.off, size: do_split_q ? need_q[31:0] : e.size, free: 1'b0,
               nxt: do_split_q ? PTR_W'(spare_q) : e.nxt};
        if (move_q) begin
          move_d = 1'b0;
          refind_d = 1'b1;
          walk_d = WALK_FIND;
        end
      end
      ST_REFIND: begin
        rd_en = 1'b1;
        cur_d = '0;
        prev_idx_d = NIL;
      end
      ST_REL: begin
        rel_idx_d = cur_q;
        rel_ent_d = e;
        rel_ent_d.free = 1'b1;
        if (!last) begin
          rd_en = 1'b1;
          raddr = e.nxt[IDX_W-1:0];
        end
      end
      ST_REL_NEXT: begin
        if (e.free) begin
          rel_ent_d.size = rel_ent_q.size + HB32 + e.size;
          rel_ent_d.nxt = e.nxt;
          in_use_d[rel_ent_q.nxt[IDX_W-1:0]] = 1'b0;
        end
      end
      ST_REL_PREV: begin
        we = 1'b1;
        if ((prev_idx_q != NIL) && prev_ent_q.free) begin
          wa = prev_idx_q[IDX_W-1:0];
          wd = '{off: prev_ent_q.off, size: prev_ent_q.size + HB32 + rel_ent_q.size,
                 free: 1'b1, nxt: rel_ent_q.nxt};
          in_use_d[rel_idx_q[IDX_W-1:0]] = 1'b0;
        end else begin
          wa = rel_idx_q[IDX_W-1:0];
          wd = rel_ent_q;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ostat_d = wstat_q;  oaddr_d = waddr_q;  ocopy_d = wcopy_q;
          otot_d = tot_q;  oused_d = usedb_q;  ofree_d = freeb_q;
          ousedsz_d = usedsz_q;  ofreesz_d = freesz_q;  olarge_d = largest_q;
        end
      end
      default: ;
    endcase

    if (cfg_wr) begin
      heap_mb_d = mb_sat;
      in_use_d = MAX_BLOCKS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (rd_en) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      heap_mb_q   <= '0;
      in_use_q    <= MAX_BLOCKS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_mb_q   <= heap_mb_d;
      in_use_q    <= in_use_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;  size_q <= size_d;  addr_q <= addr_d;
    need_q <= need_d;  split_q <= split_d;  key_q <= key_d;
    walk_q <= walk_d;  refind_q <= refind_d;  move_q <= move_d;  do_split_q <= do_split_d;
    cur_q <= cur_d;  prev_idx_q <= prev_idx_d;  rel_idx_q <= rel_idx_d;
    prev_ent_q <= prev_ent_d;  rel_ent_q <= rel_ent_d;
    spare_q <= spare_d;  scan_q <= scan_d;
    wstat_q <= wstat_d;  waddr_q <= waddr_d;  wcopy_q <= wcopy_d;
    tot_q <= tot_d;  usedb_q <= usedb_d;  freeb_q <= freeb_d;
    usedsz_q <= usedsz_d;  freesz_q <= freesz_d;  largest_q <= largest_d;
    ostat_q <= ostat_d;  oaddr_q <= oaddr_d;  ocopy_q <= ocopy_d;
    otot_q <= otot_d;  oused_q <= oused_d;  ofree_q <= ofree_d;
    ousedsz_q <= ousedsz_d;  ofreesz_q <= ofreesz_d;  olarge_q <= olarge_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = ostat_q;
  assign result_address_o     = oaddr_q;
  assign copy_bytes_o         = ocopy_q;
  assign block_count_o        = otot_q;
  assign alloc_count_o        = oused_q;
  assign vacant_count_o       = ofree_q;
  assign used_bytes_o         = ousedsz_q;
  assign free_bytes_o         = ofreesz_q;
  assign largest_free_bytes_o = olarge_q;

`ifndef SYNTHESIS
  a_head_kept: assert property (@(posedge clk_i) disable iff (!rst_ni) in_use_q[0])
    else $error("head slot lost");
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> (result_address_o == 32'd0)
                                            && (copy_bytes_o == 32'd0))
    else $error("failed request carries an address");
  a_move_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (copy_bytes_o != 32'd0) |-> (status_o == STAT_OK)
                                              && (result_address_o != 32'd0))
    else $error("moving resize without new address");
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cfg_wr |=> (state_q == ST_DISPATCH))
    else $error("accepted request not dispatched");
`endif

endmodule

>>> tb/sv/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int NSLOT = 64;
  localparam int HDR = 12;
  localparam int NIL = 64;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    mode_e mode;
    logic [31:0] size;
    logic [31:0] addr;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] addr;
    logic [31:0] copy;
    logic [6:0] total;
    logic [6:0] used;
    logic [6:0] freen;
    logic [31:0] used_b;
    logic [31:0] free_b;
    logic [31:0] largest;
  } rsp_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [1:0] mode_i, status_o;
  logic [31:0] request_size_i, block_address_i;
  logic [31:0] result_address_o, copy_bytes_o, used_bytes_o, free_bytes_o;
  logic [31:0] largest_free_bytes_o;
  logic [6:0] block_count_o, alloc_count_o, vacant_count_o;

  first_fit_heap_allocator dut (.*);

  // predicted heap state
  logic [11:0] heap_mb;
  logic [31:0] blk_off [NSLOT];
  logic [31:0] blk_size [NSLOT];
  logic blk_free [NSLOT];
  int blk_next [NSLOT];
  logic blk_used [NSLOT];

  req_t pending_q[$];
  rsp_t expected_q[$];
  logic [31:0] live_addrs[$];
  int send_idle_pct, recv_idle_pct, hold_off;
  int errors, n_xfer, n_rsp, idle_cycles;
  bit timed_out;

  function automatic void rebuild_heap();
    for (int i = 0; i < NSLOT; i++) begin
      blk_off[i] = 0;
      blk_size[i] = 0;
      blk_free[i] = 0;
      blk_next[i] = NIL;
      blk_used[i] = 0;
    end
    blk_used[0] = 1;
    blk_free[0] = 1;
    if (heap_mb != 0) blk_size[0] = ({20'd0, heap_mb} << 20) - HDR;
  endfunction

  function automatic logic [32:0] user_addr(int i);
    return 33'(HEAP_BASE) + 33'(blk_off[i]) + HDR;
  endfunction

  function automatic bit heap_alloc(logic [31:0] size, output logic [31:0] ua);
    logic [33:0] need;
    int cur, s;
    cur = 0;
    ua = 0;
    if (size == 0) return 0;
    need = (34'(size) + 7) & ~34'd7;
    for (int st = 0; st < NSLOT && cur < NSLOT; st++) begin
      if (blk_free[cur] && 34'(blk_size[cur]) >= need) begin
        if (34'(blk_size[cur]) >= need + HDR + 8) begin
          s = NIL;
          for (int i = NSLOT - 1; i >= 0; i--) if (!blk_used[i]) s = i;
          if (s < NSLOT) begin
            blk_off[s] = 32'(34'(blk_off[cur]) + HDR + need);
            blk_size[s] = 32'(34'(blk_size[cur]) - need - HDR);
            blk_free[s] = 1;
            blk_used[s] = 1;
            blk_next[s] = blk_next[cur];
            blk_size[cur] = 32'(need);
            blk_next[cur] = s;
          end
        end
        blk_free[cur] = 0;
        ua = 32'(user_addr(cur));
        return 1;
      end
      cur = blk_next[cur];
    end
    return 0;
  endfunction

  function automatic int find_alloc(logic [31:0] a, output int prev);
    int cur, p;
    cur = 0;
    p = NIL;
    for (int st = 0; st < NSLOT && cur < NSLOT; st++) begin
      if (!blk_free[cur] && user_addr(cur) == 33'(a)) begin
        prev = p;
        return cur;
      end
      p = cur;
      cur = blk_next[cur];
    end
    prev = NIL;
    return NIL;
  endfunction

  function automatic void drop_blk(int i);
    blk_used[i] = 0;
    blk_free[i] = 0;
    blk_next[i] = NIL;
    blk_off[i] = 0;
    blk_size[i] = 0;
  endfunction

  function automatic void heap_release(int idx, int prev);
    int n;
    blk_free[idx] = 1;
    n = blk_next[idx];
    if (n < NSLOT && blk_free[n]) begin
      blk_size[idx] += HDR + blk_size[n];
      blk_next[idx] = blk_next[n];
      drop_blk(n);
    end
    if (prev < NSLOT && blk_free[prev]) begin
      blk_size[prev] += HDR + blk_size[idx];
      blk_next[prev] = blk_next[idx];
      drop_blk(idx);
    end
  endfunction

  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    logic [31:0] ua, old;
    int idx, prev, cur;
    o = '0;
    if (heap_mb == 0) begin
      o.status = STAT_NOMEM;
      return o;
    end
    case (r.mode)
      MODE_ALLOC: begin
        if (heap_alloc(r.size, ua)) o.addr = ua;
        else o.status = STAT_NOMEM;
      end
      MODE_RELEASE: begin
        if (r.addr != 0) begin
          idx = find_alloc(r.addr, prev);
          if (idx >= NSLOT) o.status = STAT_UNKNOWN;
          else heap_release(idx, prev);
        end
      end
      MODE_RESIZE: begin
        if (r.addr == 0) begin
          if (heap_alloc(r.size, ua)) o.addr = ua;
          else o.status = STAT_NOMEM;
        end else begin
          idx = find_alloc(r.addr, prev);
          if (idx >= NSLOT) o.status = STAT_UNKNOWN;
          else if (r.size == 0) heap_release(idx, prev);
          else if (blk_size[idx] >= r.size) o.addr = r.addr;
          else begin
            old = blk_size[idx];
            if (heap_alloc(r.size, ua)) begin
              o.addr = ua;
              o.copy = old;
              idx = find_alloc(r.addr, prev);
              if (idx < NSLOT) heap_release(idx, prev);
            end else o.status = STAT_NOMEM;
          end
        end
      end
      default: begin
        cur = 0;
        for (int st = 0; st < NSLOT && cur < NSLOT; st++) begin
          o.total++;
          if (blk_free[cur]) begin
            o.freen++;
            o.free_b += blk_size[cur];
            if (blk_size[cur] > o.largest) o.largest = blk_size[cur];
          end else begin
            o.used++;
            o.used_b += blk_size[cur];
          end
          cur = blk_next[cur];
        end
      end
    endcase
    return o;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // request driver
  always @(negedge clk_i) begin
    if (in_valid_i && !in_ready_o) begin
    end else if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_valid_i <= 1;
      mode_i <= pending_q[0].mode;
      request_size_i <= pending_q[0].size;
      block_address_i <= pending_q[0].addr;
      void'(pending_q.pop_front());
    end else in_valid_i <= 0;
  end

  // result ready
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 0;
      hold_off <= hold_off - 1;
    end else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t got, exp_r;
    req_t r;
    bit moved;
    moved = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        r.mode = mode_e'(mode_i);
        r.size = request_size_i;
        r.addr = block_address_i;
        exp_r = heap_apply(r);
        expected_q.push_back(exp_r);
        if (exp_r.addr != 0 && exp_r.addr != r.addr) live_addrs.push_back(exp_r.addr);
        n_xfer <= n_xfer + 1;
        moved = 1;
      end
      if (out_valid_o && out_ready_i) begin
        moved = 1;
        n_rsp <= n_rsp + 1;
        got = {status_o, result_address_o, copy_bytes_o, block_count_o, alloc_count_o,
               vacant_count_o, used_bytes_o, free_bytes_o, largest_free_bytes_o};
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (got.status !== exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.addr !== exp_r.addr) begin
            $error("result_address exp %h got %h", exp_r.addr, got.addr); errors++;
          end
          if (got.copy !== exp_r.copy) begin
            $error("copy_bytes exp %0d got %0d", exp_r.copy, got.copy); errors++;
          end
          if (got.total !== exp_r.total) begin
            $error("block_count exp %0d got %0d", exp_r.total, got.total); errors++;
          end
          if (got.used !== exp_r.used) begin
            $error("alloc_count exp %0d got %0d", exp_r.used, got.used); errors++;
          end
          if (got.freen !== exp_r.freen) begin
            $error("vacant_count exp %0d got %0d", exp_r.freen, got.freen); errors++;
          end
          if (got.used_b !== exp_r.used_b) begin
            $error("used_bytes exp %0d got %0d", exp_r.used_b, got.used_b); errors++;
          end
          if (got.free_b !== exp_r.free_b) begin
            $error("free_bytes exp %0d got %0d", exp_r.free_b, got.free_b); errors++;
          end
          if (got.largest !== exp_r.largest) begin
            $error("largest_free_bytes exp %0d got %0d", exp_r.largest, got.largest);
            errors++;
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_heap_mb(logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 3'(REG_HEAP_MB) << 2; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    if (pready) begin
      heap_mb = (v[11:0] > MB_LIMIT) ? MB_LIMIT : v[11:0];
      rebuild_heap();
      live_addrs.delete();
    end
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    repeat (4) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic add(mode_e m, logic [31:0] s, logic [31:0] a);
    req_t r;
    r.mode = m; r.size = s; r.addr = a;
    pending_q.push_back(r);
  endtask

  function automatic logic [31:0] rand_size();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(8);
      2, 3, 4: return $urandom_range(4096);
      default: return $urandom_range(200000);
    endcase
  endfunction

  task automatic rand_phase(int n);
    logic [31:0] a;
    int k;
    for (int i = 0; i < n; i++) begin
      // pick from addresses handed out so far; some are already stale
      k = $urandom_range(99);
      if (live_addrs.size() != 0) a = live_addrs[$urandom_range(live_addrs.size() - 1)];
      else a = HEAP_BASE + HDR;
      if ($urandom_range(9) == 0) a = $urandom();
      if (k < 40) add(MODE_ALLOC, rand_size(), $urandom());
      else if (k < 70) add(MODE_RELEASE, $urandom(), ($urandom_range(19) == 0) ? 0 : a);
      else if (k < 90) add(MODE_RESIZE, rand_size(), ($urandom_range(9) == 0) ? 0 : a);
      else add(MODE_STATS, $urandom(), $urandom());
      while (pending_q.size() > 4) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; mode_i = 0; request_size_i = 0; block_address_i = 0;
    out_ready_i = 0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_off = 0;
    errors = 0; n_xfer = 0; n_rsp = 0; idle_cycles = 0; timed_out = 0;
    heap_mb = 0;
    rebuild_heap();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (4) @(posedge clk_i);

    // uninitialized heap answers no memory in every mode
    add(MODE_ALLOC, 16, 0);
    add(MODE_RELEASE, 0, HEAP_BASE + HDR);
    add(MODE_RESIZE, 8, 0);
    add(MODE_STATS, 0, 0);
    drain();

    write_heap_mb(32'hFFF);
    add(MODE_STATS, 0, 0);
    add(MODE_ALLOC, 32'hFFFF_FFFF, 0);
    add(MODE_ALLOC, 0, 0);
    add(MODE_ALLOC, 1, 32'hFFFF_FFFF);
    add(MODE_ALLOC, 100, 0);
    add(MODE_ALLOC, 24, 0);
    add(MODE_RELEASE, 0, 0);
    add(MODE_RELEASE, 0, 32'h1234_5678);
    add(MODE_RESIZE, 4, HEAP_BASE + HDR);
    add(MODE_RESIZE, 5000, HEAP_BASE + HDR);
    add(MODE_RELEASE, 0, HEAP_BASE + HDR);
    add(MODE_RESIZE, 0, HEAP_BASE + HDR + 8 + HDR + 104);
    add(MODE_RESIZE, 64, 0);
    add(MODE_RESIZE, 32'hFFFF_FFF0, HEAP_BASE + HDR);
    add(MODE_STATS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // fill the table so allocations stop splitting
    write_heap_mb(1);
    for (int i = 0; i < 70; i++) add(MODE_ALLOC, 8, 0);
    add(MODE_STATS, 0, 0);
    add(MODE_ALLOC, 8, 0);
    drain();

    send_idle_pct = 16; recv_idle_pct = 85;
    write_heap_mb(2);
    rand_phase(600);
    drain();

    send_idle_pct = 85; recv_idle_pct = 16;
    write_heap_mb(3064);
    rand_phase(500);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_heap_mb($urandom_range(1, 8));
    hold_off = 3000;
    rand_phase(600);
    drain();

    $display("covered %0d requests, %0d results checked, heap sizes 0..3064 MiB",
             n_xfer, n_rsp);
    $display("modes allocate/release/resize/statistics with idle, stall and full-table cases");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
